// File: hw/rtl/gpf_pkg.sv
// Shared types, constants and the colour quantiser for the GIF pixel framer.
package gpf_pkg;

    // Width of the pixel counter within one image.
    localparam int COUNT_BITS = 20;
    // Width of the pixel total register.
    localparam int TOTAL_BITS = 20;

    // Sub-block and code constants of the image data stream.
    localparam logic [6:0] SEG_MAX    = 7'd125;
    localparam logic [7:0] CLEAR_CODE = 8'd128;
    localparam logic [7:0] END_CODE   = 8'd129;
    localparam logic [7:0] ONE_BYTE   = 8'd1;
    localparam logic [7:0] TERM_BYTE  = 8'd0;

    // Reset value of the pixel total.
    localparam logic [TOTAL_BITS-1:0] TOTAL_RESET = TOTAL_BITS'(80000);

    // Register indexes of the configuration port.
    localparam logic REG_PIXEL_TOTAL = 1'b0;

    // Command queue between the front and back parts.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    // One classified pixel: its palette code and the framing around it.
    typedef struct packed {
        logic [6:0] code;
        logic       hdr;
        logic [7:0] len;
        logic       tail;
    } t_cmd;

    // Byte positions of the output sequencer, one-hot.
    typedef enum logic [5:0] {
        ST_LEN  = 6'b000001,
        ST_CLR  = 6'b000010,
        ST_CODE = 6'b000100,
        ST_ONE  = 6'b001000,
        ST_END  = 6'b010000,
        ST_TERM = 6'b100000
    } t_step;

    // Quantises one channel to 0..4, equal to (c + 31) * 4 / 255.
    function automatic logic [2:0] quant_channel(input logic [7:0] c);
        logic [2:0] q;
        q = 3'd0;
        if (c >= 8'd33)  q = 3'd1;
        if (c >= 8'd97)  q = 3'd2;
        if (c >= 8'd161) q = 3'd3;
        if (c >= 8'd224) q = 3'd4;
        return q;
    endfunction

    // Palette index 25*r + 5*g + b of a 24-bit RGB pixel.
    function automatic logic [6:0] palette_code(input logic [23:0] rgb);
        logic [6:0] r;
        logic [6:0] g;
        logic [6:0] b;
        r = 7'(quant_channel(rgb[23:16]));
        g = 7'(quant_channel(rgb[15:8]));
        b = 7'(quant_channel(rgb[7:0]));
        return 7'(r * 7'd25 + g * 7'd5 + b);
    endfunction

endpackage

// File: hw/rtl/gpf_front.sv
// Front part: accepts pixels, quantises them and decides the framing around each.
module gpf_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_pixel_valid,
    output logic                           o_pixel_ready,
    input  logic [23:0]                    i_pixel_color,
    input  logic [gpf_pkg::TOTAL_BITS-1:0] i_pixel_total,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output gpf_pkg::t_cmd                  o_q_cmd
);

    logic [gpf_pkg::COUNT_BITS-1:0] r_pixels_done, n_pixels_done;
    logic [6:0]                     r_seg_pos, n_seg_pos;
    logic [gpf_pkg::COUNT_BITS-1:0] total;
    logic [gpf_pkg::COUNT_BITS-1:0] remaining;
    logic [gpf_pkg::COUNT_BITS-1:0] done_inc;
    logic [6:0]                     seg_len;
    logic                           accept;
    logic                           hdr;
    logic                           tail;

    assign o_pixel_ready = !i_q_full;
    assign accept        = i_pixel_valid && o_pixel_ready;

    // Length of a new sub-block: the pixels still to come, at most a full block.
    assign total     = gpf_pkg::COUNT_BITS'(i_pixel_total);
    assign remaining = total - r_pixels_done;
    assign seg_len   = (remaining < gpf_pkg::COUNT_BITS'(gpf_pkg::SEG_MAX))
                       ? remaining[6:0] : gpf_pkg::SEG_MAX;
    assign hdr       = (r_seg_pos == 7'd0);

    // The image ends with the pixel that brings the count to the total.
    assign done_inc = r_pixels_done + gpf_pkg::COUNT_BITS'(1);
    assign tail     = (done_inc == total);

    // Command handed to the queue.
    always_comb begin
        o_q_cmd.code = gpf_pkg::palette_code(i_pixel_color);
        o_q_cmd.hdr  = hdr;
        o_q_cmd.len  = {1'b0, seg_len} + 8'd1;
        o_q_cmd.tail = tail;
    end
    assign o_q_push = accept;

    // Counter updates for each accepted pixel.
    always_comb begin
        n_pixels_done = r_pixels_done;
        n_seg_pos     = r_seg_pos;
        if (accept) begin
            if (tail) begin
                n_pixels_done = '0;
                n_seg_pos     = 7'd0;
            end else begin
                n_pixels_done = done_inc;
                n_seg_pos     = (r_seg_pos == gpf_pkg::SEG_MAX - 7'd1) ? 7'd0
                                : r_seg_pos + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixels_done <= '0;
            r_seg_pos     <= 7'd0;
        end else begin
            r_pixels_done <= n_pixels_done;
            r_seg_pos     <= n_seg_pos;
        end
    end

endmodule

// File: hw/rtl/gpf_queue.sv
// Short command queue between the front and back parts.
module gpf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gpf_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output gpf_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    gpf_pkg::t_cmd              r_mem [gpf_pkg::QDEPTH];
    logic [gpf_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [gpf_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [gpf_pkg::QPTR_W:0]   r_count, n_count;

    assign o_full  = (r_count == (gpf_pkg::QPTR_W+1)'(gpf_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointer and occupancy updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + gpf_pkg::QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + gpf_pkg::QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (gpf_pkg::QPTR_W+1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (gpf_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: hw/rtl/gpf_back.sv
// Back part: turns queued commands into bytes, one byte per cycle unless the output stalls.
module gpf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gpf_pkg::t_cmd i_q_cmd,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    output logic          o_byte_valid,
    input  logic          i_byte_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_last_of_run,
    output logic          o_image_end
);

    gpf_pkg::t_cmd  r_cmd;
    gpf_pkg::t_step r_step;
    logic           r_busy;
    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic           r_last;
    logic           r_end;

    gpf_pkg::t_cmd  cur;
    gpf_pkg::t_step step;
    gpf_pkg::t_step nxt_step;
    logic           have;
    logic           fire;
    logic           done;
    logic [7:0]     byte_val;

    // The command in work is either held or taken straight from the queue head.
    assign cur  = r_busy ? r_cmd : i_q_cmd;
    assign have = r_busy || !i_q_empty;
    assign step = r_busy ? r_step
                  : (i_q_cmd.hdr ? gpf_pkg::ST_LEN : gpf_pkg::ST_CODE);
    assign fire = have && (!r_out_valid || i_byte_ready);
    assign o_q_pop = fire && !r_busy;

    // Byte for the current position and the position that follows it.
    always_comb begin
        byte_val = gpf_pkg::TERM_BYTE;
        nxt_step = gpf_pkg::ST_CODE;
        done     = 1'b0;
        case (step)
            gpf_pkg::ST_LEN: begin
                byte_val = cur.len;
                nxt_step = gpf_pkg::ST_CLR;
            end
            gpf_pkg::ST_CLR: begin
                byte_val = gpf_pkg::CLEAR_CODE;
                nxt_step = gpf_pkg::ST_CODE;
            end
            gpf_pkg::ST_CODE: begin
                byte_val = {1'b0, cur.code};
                nxt_step = gpf_pkg::ST_ONE;
                done     = !cur.tail;
            end
            gpf_pkg::ST_ONE: begin
                byte_val = gpf_pkg::ONE_BYTE;
                nxt_step = gpf_pkg::ST_END;
            end
            gpf_pkg::ST_END: begin
                byte_val = gpf_pkg::END_CODE;
                nxt_step = gpf_pkg::ST_TERM;
            end
            gpf_pkg::ST_TERM: begin
                byte_val = gpf_pkg::TERM_BYTE;
                done     = 1'b1;
            end
            default: begin
                byte_val = gpf_pkg::TERM_BYTE;
                done     = 1'b1;
            end
        endcase
    end

    // Sequencer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= gpf_pkg::ST_CODE;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_busy      <= !done;
                r_step      <= nxt_step;
                r_out_valid <= 1'b1;
            end else if (i_byte_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Held command and output register.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (fire) begin
            r_out_byte <= byte_val;
            r_last     <= done;
            r_end      <= (step == gpf_pkg::ST_TERM);
        end
    end

    assign o_byte_valid  = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_last;
    assign o_image_end   = r_end;

endmodule

// File: hw/rtl/gif_uncompressed_pixel_framer_top.sv
// Top level of the GIF pixel framer: configuration register and the two parts.
//
//   Channel   Direction  Handshake                          Payload
//   pixel     in         i_pixel_valid / o_pixel_ready      i_pixel_color
//   byte      out        o_byte_valid / i_byte_ready        o_out_byte, o_last_of_run,
//                                                           o_image_end
//   config    in         psel, penable, pwrite, pready      paddr, pwdata, prdata
//
// The output sequencer sends one byte per cycle while the sink is ready, so a pixel
// takes one byte inside a sub-block, three at the start of a sub-block and three more at
// the end of the image. A pixel is taken whenever the four-entry command queue has room,
// so the front keeps accepting while the back drains. Reset is synchronous and clears the
// counters, the queue and the output valid flag; the pixel total returns to 80000.
module gif_uncompressed_pixel_framer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pixel_valid,
    output logic        o_pixel_ready,
    input  logic [23:0] i_pixel_color,
    output logic        o_byte_valid,
    input  logic        i_byte_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_image_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [gpf_pkg::TOTAL_BITS-1:0] r_pixel_total;
    logic                           cfg_wr;
    logic                           q_push;
    logic                           q_pop;
    logic                           q_full;
    logic                           q_empty;
    gpf_pkg::t_cmd                  q_in;
    gpf_pkg::t_cmd                  q_out;

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_total <= gpf_pkg::TOTAL_RESET;
        end else if (cfg_wr && (paddr[2] == gpf_pkg::REG_PIXEL_TOTAL)) begin
            r_pixel_total <= pwdata[gpf_pkg::TOTAL_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == gpf_pkg::REG_PIXEL_TOTAL) ? 32'(r_pixel_total) : 32'd0;

    // Front, queue and back.
    gpf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_pixel_color (i_pixel_color),
        .i_pixel_total (r_pixel_total),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_cmd       (q_in)
    );

    gpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_empty (q_empty)
    );

    gpf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_cmd       (q_out),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .o_byte_valid  (o_byte_valid),
        .i_byte_ready  (i_byte_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_image_end   (o_image_end)
    );

endmodule
